[rtl/core/base64_stream_codec_defines.svh]
// ----------------------------------------------------------------------------
// base64_stream_codec_defines
// Assertion macros used by the codec top level.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_DEFINES_SVH
`define BASE64_STREAM_CODEC_DEFINES_SVH

`ifndef ASSERT_OFF
// property holds at every clock outside reset
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/core/bs64_pkg.sv]
// ----------------------------------------------------------------------------
// bs64_pkg
// Types, constants and alphabet functions of the Base64 stream codec.
// ----------------------------------------------------------------------------
`default_nettype none

package bs64_pkg;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_has_value;
    logic       out_last;
    logic       out_bad_char;
  } out_item_t;

  // results caused by one request, emitted in order val[0] .. val[cnt-1]
  typedef struct packed {
    logic [2:0]                  cnt;
    logic [MAX_RESULTS-1:0][7:0] val;
    logic                        has;
    logic                        last;
    logic                        bad;
  } job_t;

  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_t;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] s8;
    s8 = {2'b00, s};
    if (s < 6'd26) return 8'h41 + s8;
    else if (s < 6'd52) return 8'h61 + s8 - 8'd26;
    else if (s < 6'd62) return 8'h30 + s8 - 8'd52;
    else if (s == 6'd62) return 8'h2B;
    else return 8'h2F;
  endfunction

  function automatic sym_t b64_sym(input logic [7:0] c);
    sym_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) r.val = 6'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) r.val = 6'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) r.val = 6'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B) r.val = 6'd62;
    else if (c == 8'h2F) r.val = 6'd63;
    else r.ok = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bs64_front.sv]
// ----------------------------------------------------------------------------
// bs64_front
// Accepts requests, keeps mode, leftover bits and phase, builds result jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module bs64_front import bs64_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wdata,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire q_stat_t  q_stat,
  output logic          push,
  output job_t          push_job
);

  logic       mode_r;
  logic [5:0] hold_r, hold_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       accept;
  logic [7:0] b;
  sym_t       sym;
  job_t       job;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign b        = in_data.in_byte;
  assign sym      = b64_sym(b);

  always_comb begin
    job       = '0;
    hold_nxt  = hold_r;
    phase_nxt = phase_r;
    job.last  = in_data.in_last;
    if (mode_r == MODE_ENC) begin
      job.has = 1'b1;
      case (phase_r)
        2'd1: begin
          job.val[0] = b64_char({hold_r[1:0], b[7:4]});
          hold_nxt   = {2'b00, b[3:0]};
          phase_nxt  = 2'd2;
          if (in_data.in_last) begin
            job.cnt    = 3'd3;
            job.val[1] = b64_char({b[3:0], 2'b00});
            job.val[2] = PAD_CHAR;
          end else begin
            job.cnt = 3'd1;
          end
        end
        2'd2: begin
          job.cnt    = 3'd2;
          job.val[0] = b64_char({hold_r[3:0], b[7:6]});
          job.val[1] = b64_char(b[5:0]);
          hold_nxt   = 6'd0;
          phase_nxt  = 2'd0;
        end
        default: begin
          job.val[0] = b64_char(b[7:2]);
          hold_nxt   = {4'b0000, b[1:0]};
          phase_nxt  = 2'd1;
          if (in_data.in_last) begin
            job.cnt    = 3'd4;
            job.val[1] = b64_char({b[1:0], 4'b0000});
            job.val[2] = PAD_CHAR;
            job.val[3] = PAD_CHAR;
          end else begin
            job.cnt = 3'd1;
          end
        end
      endcase
    end else begin
      if (b == PAD_CHAR) begin
        job.cnt = in_data.in_last ? 3'd1 : 3'd0;
      end else if (!sym.ok) begin
        job.cnt = 3'd1;
        job.bad = 1'b1;
      end else begin
        case (phase_r)
          2'd0: begin
            job.cnt   = in_data.in_last ? 3'd1 : 3'd0;
            hold_nxt  = sym.val;
            phase_nxt = 2'd1;
          end
          2'd1: begin
            job.cnt    = 3'd1;
            job.has    = 1'b1;
            job.val[0] = {hold_r, sym.val[5:4]};
            hold_nxt   = {2'b00, sym.val[3:0]};
            phase_nxt  = 2'd2;
          end
          2'd2: begin
            job.cnt    = 3'd1;
            job.has    = 1'b1;
            job.val[0] = {hold_r[3:0], sym.val[5:2]};
            hold_nxt   = {4'b0000, sym.val[1:0]};
            phase_nxt  = 2'd3;
          end
          default: begin
            job.cnt    = 3'd1;
            job.has    = 1'b1;
            job.val[0] = {hold_r[1:0], sym.val};
            hold_nxt   = 6'd0;
            phase_nxt  = 2'd0;
          end
        endcase
      end
    end
    if (in_data.in_last) begin
      hold_nxt  = 6'd0;
      phase_nxt = 2'd0;
    end
  end

  assign push     = accept && (job.cnt != 3'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ENC;
      hold_r  <= 6'd0;
      phase_r <= 2'd0;
    end else if (cfg_wr_en) begin
      mode_r  <= cfg_wdata;
      hold_r  <= 6'd0;
      phase_r <= 2'd0;
    end else if (accept) begin
      hold_r  <= hold_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bs64_queue.sv]
// ----------------------------------------------------------------------------
// bs64_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bs64_queue import bs64_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job,
  output q_stat_t   stat
);

  job_t       mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == 2'(QUEUE_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bs64_back.sv]
// ----------------------------------------------------------------------------
// bs64_back
// Takes queue jobs, sends their results one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module bs64_back import bs64_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  job_t       job_r;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       out_load, emit, final_ent;

  assign out_load  = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_load;
  assign final_ent = ({1'b0, idx_r} + 3'd1) == job_r.cnt;
  assign pop       = q_valid && (!busy_r || (emit && final_ent));

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) out_valid_nxt = 1'b0;
    if (emit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.out_value     = job_r.val[idx_r];
      out_data_nxt.out_has_value = job_r.has;
      out_data_nxt.out_last      = job_r.last && final_ent;
      out_data_nxt.out_bad_char  = job_r.bad;
      idx_nxt                    = idx_r + 2'd1;
      if (final_ent) busy_nxt = 1'b0;
    end
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= q_job;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/base64_stream_codec.sv]
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder, standard alphabet, '=' padding.
// ----------------------------------------------------------------------------
// Usage: cfg_wr_en/cfg_wdata write the mode (0 encode, 1 decode) and clear
// the message state; write only while the block is idle. Requests arrive on
// in_valid/in_stall/in_data, one byte (encode) or character (decode) each,
// in_last closing the message. Results leave on out_valid/out_stall/out_data.
// Encode gives 1 to 4 characters per byte, decode 0 or 1 byte per character;
// a decode invalid character gives one flagged result with no value.
// A request's first result is registered in the job queue, the back's job
// register and the output register. Throughput: one result per cycle while
// out_stall is low, set by the single output register; a new request is
// taken every cycle while the two-entry job queue has room; decoding runs at
// one character a cycle, encoding is bound by its results. While out_stall
// is high the result holds; the back takes one more job and the queue two,
// then in_stall rises. Reset: encode mode; state, queue, output valid clear.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_codec_defines.svh"

module base64_stream_codec import bs64_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wdata,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  q_stat_t q_stat;
  logic    push, pop, head_valid;
  job_t    push_job, head_job;

  bs64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  bs64_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .stat       (q_stat)
  );

  bs64_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_job     (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ASSERT_ALWAYS(a_queue_bound, q_stat.count <= 2'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_no_value_zero, out_valid && !out_data.out_has_value, out_data.out_value == 8'd0)
  `ASSERT_IMPLIES(a_bad_no_value, out_valid && out_data.out_bad_char, !out_data.out_has_value)
  `ASSERT_NEXT(a_full_stalls, q_stat.full && !pop, in_stall)

endmodule

`default_nettype wire
